>>> sv/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next cycle");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> sv/acpd_pkg.sv
package acpd_pkg;

   localparam int POS_W  = 16;
   localparam int ERR_W  = 17;
   localparam int MEAN_W = 17;
   localparam int THR_W  = 15;
   localparam int DUR_W  = 16;
   localparam int DIR_W  = 3;
   localparam int CSR_IDX_W = 2;

   localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(205);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD_X = 2'd0,
      CSR_THRESHOLD_Y = 2'd1
   } csr_index_type;

   typedef enum logic [DIR_W-1:0] {
      DIR_NONE     = 3'd0,
      DIR_FORWARD  = 3'd1,
      DIR_BACKWARD = 3'd2,
      DIR_LEFT     = 3'd3,
      DIR_RIGHT    = 3'd4
   } dir_type;

   // Per-lane control: load/clear/full/update refer to the request in flight.
   typedef struct packed {
      logic load;    // request accepted: window read and write issued
      logic move;    // stage 1 request advances, sums and means update
      logic clear;   // stage 1 request started from an empty history
      logic full;    // window was full before stage 1 request
      logic update;  // window full after stage 1 request: refresh held mean
   } lane_ctl_type;

endpackage

>>> sv/acpd_ram.sv
module acpd_ram #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // read-during-write returns the old entry
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

>>> sv/acpd_lane.sv
module acpd_lane #(
   parameter int WINDOW = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  acpd_pkg::lane_ctl_type                ctl,
   input  logic [$clog2(WINDOW)-1:0]             idx,
   input  logic signed [acpd_pkg::POS_W-1:0]     measured_x,
   input  logic signed [acpd_pkg::POS_W-1:0]     measured_y,
   input  logic signed [acpd_pkg::POS_W-1:0]     requested_x,
   input  logic signed [acpd_pkg::POS_W-1:0]     requested_y,
   output logic signed [acpd_pkg::MEAN_W-1:0]    mean_x,
   output logic signed [acpd_pkg::MEAN_W-1:0]    mean_y
);
   import acpd_pkg::*;

   localparam int IDX_W = $clog2(WINDOW);
   localparam int SUM_W = ERR_W + IDX_W;

   logic signed [ERR_W-1:0] err [2];
   logic signed [ERR_W-1:0] err_s1_ff [2];
   logic signed [ERR_W-1:0] old_e [2];
   logic signed [SUM_W-1:0] sum_ff [2];
   logic signed [SUM_W-1:0] sum_in [2];
   logic signed [SUM_W-1:0] sum_base [2];
   logic signed [SUM_W-1:0] old_ext [2];
   logic signed [SUM_W-1:0] shifted [2];
   logic signed [MEAN_W-1:0] mean_ff [2];
   logic signed [MEAN_W-1:0] mean_in [2];
   logic [2*ERR_W-1:0] rdata;

   assign err[0] = ERR_W'(measured_x) - ERR_W'(requested_x);
   assign err[1] = ERR_W'(measured_y) - ERR_W'(requested_y);

   acpd_ram #(
      .WIDTH (2*ERR_W),
      .DEPTH (WINDOW)
   ) u_window (
      .clock (clock),
      .we    (ctl.load),
      .waddr (idx),
      .wdata ({err[1], err[0]}),
      .re    (ctl.load),
      .raddr (idx),
      .rdata (rdata)
   );

   assign old_e[0] = rdata[ERR_W-1:0];
   assign old_e[1] = rdata[2*ERR_W-1:ERR_W];

   for (genvar a = 0; a < 2; a++) begin : g_axis
      always_comb begin
         sum_base[a] = ctl.clear ? '0 : sum_ff[a];
         old_ext[a]  = ctl.full ? SUM_W'(old_e[a]) : '0;
         sum_in[a]   = sum_base[a] - old_ext[a] + SUM_W'(err_s1_ff[a]);
         shifted[a]  = sum_in[a] >>> IDX_W;
         if (ctl.update) begin
            mean_in[a] = shifted[a][MEAN_W-1:0];
         end else begin
            mean_in[a] = ctl.clear ? '0 : mean_ff[a];
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.load) begin
            err_s1_ff[a] <= err[a];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sum_ff[a]  <= '0;
            mean_ff[a] <= '0;
         end else if (ctl.move) begin
            sum_ff[a]  <= sum_in[a];
            mean_ff[a] <= mean_in[a];
         end
      end
   end

   assign mean_x = mean_ff[0];
   assign mean_y = mean_ff[1];

endmodule

>>> sv/acpd_judge.sv
module acpd_judge (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load,
   input  logic                               clear,
   input  logic signed [acpd_pkg::MEAN_W-1:0] mean_x,
   input  logic signed [acpd_pkg::MEAN_W-1:0] mean_y,
   input  logic [acpd_pkg::THR_W-1:0]         threshold_x,
   input  logic [acpd_pkg::THR_W-1:0]         threshold_y,
   output logic                               contact,
   output logic [acpd_pkg::DIR_W-1:0]         direction,
   output logic [acpd_pkg::DUR_W-1:0]         duration
);
   import acpd_pkg::*;

   logic [MEAN_W-1:0] abs_x;
   logic [MEAN_W-1:0] abs_y;
   logic              cx;
   logic              cy;
   dir_type           dir;
   logic [DUR_W-1:0]  count_base;
   logic [DUR_W-1:0]  count_in;
   logic [DUR_W-1:0]  count_ff;
   logic              contact_ff;
   dir_type           dir_ff;

   always_comb begin
      abs_x = mean_x[MEAN_W-1] ? MEAN_W'(-mean_x) : MEAN_W'(mean_x);
      abs_y = mean_y[MEAN_W-1] ? MEAN_W'(-mean_y) : MEAN_W'(mean_y);
      cx    = abs_x > MEAN_W'(threshold_x);
      cy    = abs_y > MEAN_W'(threshold_y);

      priority if (cx) begin
         dir = mean_x[MEAN_W-1] ? DIR_BACKWARD : DIR_FORWARD;
      end else if (cy) begin
         dir = mean_y[MEAN_W-1] ? DIR_RIGHT : DIR_LEFT;
      end else begin
         dir = DIR_NONE;
      end

      count_base = clear ? '0 : count_ff;
      if (cx || cy) begin
         count_in = (&count_base) ? count_base : DUR_W'(count_base + 1'b1);
      end else begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (load) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         contact_ff <= cx || cy;
         dir_ff     <= dir;
      end
   end

   assign contact   = contact_ff;
   assign direction = dir_ff;
   assign duration  = count_ff;

endmodule

>>> sv/arm_contact_push_detector.sv
// Channel  | Handshake             | Carries
// req      | req_valid/req_ready   | clear flag, measured and requested x/y per arm
// rsp      | rsp_valid/rsp_ready   | contact, direction, duration per arm
// csr      | csr_valid/csr_ready   | threshold index and value, always ready
//
// One request per cycle sustained while responses are taken; each request passes through the window
// memory read, the running sum and mean, and the contact decision into the output register.
// The window memory is one RAM per arm, one read and one write port, both at the write index.
// Reset clears indexes, sums, held means and duration counters; window contents need no clear.
// A stalled response holds the pipeline; req_ready drops only once every stage is occupied.
`include "assert_macros.svh"

module arm_contact_push_detector #(
   parameter int WINDOW = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_clear_history,
   input  logic signed [acpd_pkg::POS_W-1:0]   req_measured_left_x,
   input  logic signed [acpd_pkg::POS_W-1:0]   req_measured_left_y,
   input  logic signed [acpd_pkg::POS_W-1:0]   req_requested_left_x,
   input  logic signed [acpd_pkg::POS_W-1:0]   req_requested_left_y,
   input  logic signed [acpd_pkg::POS_W-1:0]   req_measured_right_x,
   input  logic signed [acpd_pkg::POS_W-1:0]   req_measured_right_y,
   input  logic signed [acpd_pkg::POS_W-1:0]   req_requested_right_x,
   input  logic signed [acpd_pkg::POS_W-1:0]   req_requested_right_y,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_left_contact,
   output logic                                rsp_right_contact,
   output logic [acpd_pkg::DIR_W-1:0]          rsp_direction_left,
   output logic [acpd_pkg::DIR_W-1:0]          rsp_direction_right,
   output logic [acpd_pkg::DUR_W-1:0]          rsp_left_duration,
   output logic [acpd_pkg::DUR_W-1:0]          rsp_right_duration,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [acpd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [acpd_pkg::THR_W-1:0]          csr_wdata
);
   import acpd_pkg::*;

   localparam int IDX_W  = $clog2(WINDOW);
   localparam int FILL_W = $clog2(WINDOW + 1);

   logic [THR_W-1:0]  thr_x_ff;
   logic [THR_W-1:0]  thr_y_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [IDX_W-1:0]  idx_in;
   logic [IDX_W-1:0]  base_idx;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic [FILL_W-1:0] base_fill;
   logic              full_now;
   logic              update_now;

   logic s1_valid_ff;
   logic s1_clear_ff;
   logic s1_full_ff;
   logic s1_update_ff;
   logic s2_valid_ff;
   logic s2_clear_ff;
   logic rsp_valid_ff;

   logic accept;
   logic out_free;
   logic s2_move;
   logic s2_open;
   logic s1_move;
   logic s1_open;

   logic fill_grow;
   logic left_idle;
   logic right_busy;

   lane_ctl_type ctl;

   logic signed [MEAN_W-1:0] mean_lx;
   logic signed [MEAN_W-1:0] mean_ly;
   logic signed [MEAN_W-1:0] mean_rx;
   logic signed [MEAN_W-1:0] mean_ry;

   // flow control
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s2_move   = s2_valid_ff && out_free;
   assign s2_open   = !s2_valid_ff || out_free;
   assign s1_move   = s1_valid_ff && s2_open;
   assign s1_open   = !s1_valid_ff || s2_open;
   assign req_ready = s1_open;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign csr_ready = 1'b1;

   // window position for the incoming request
   always_comb begin
      base_idx   = req_clear_history ? '0 : idx_ff;
      base_fill  = req_clear_history ? '0 : fill_ff;
      full_now   = base_fill == FILL_W'(WINDOW);
      update_now = full_now || (base_fill == FILL_W'(WINDOW - 1));
      idx_in     = (base_idx == IDX_W'(WINDOW - 1)) ? '0 : IDX_W'(base_idx + 1'b1);
      fill_in    = full_now ? base_fill : FILL_W'(base_fill + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_x_ff     <= THRESHOLD_RESET;
         thr_y_ff     <= THRESHOLD_RESET;
         idx_ff       <= '0;
         fill_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_THRESHOLD_X: thr_x_ff <= csr_wdata;
               CSR_THRESHOLD_Y: thr_y_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            idx_ff  <= idx_in;
            fill_ff <= fill_in;
         end
         s1_valid_ff  <= accept || (s1_valid_ff && !s1_move);
         s2_valid_ff  <= s1_move || (s2_valid_ff && !s2_move);
         rsp_valid_ff <= s2_move || (rsp_valid_ff && !rsp_ready);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_clear_ff  <= req_clear_history;
         s1_full_ff   <= full_now;
         s1_update_ff <= update_now;
      end
      if (s1_move) begin
         s2_clear_ff <= s1_clear_ff;
      end
   end

   assign ctl = '{
      load:   accept,
      move:   s1_move,
      clear:  s1_clear_ff,
      full:   s1_full_ff,
      update: s1_update_ff
   };

   acpd_lane #(.WINDOW (WINDOW)) u_lane_left (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .idx         (base_idx),
      .measured_x  (req_measured_left_x),
      .measured_y  (req_measured_left_y),
      .requested_x (req_requested_left_x),
      .requested_y (req_requested_left_y),
      .mean_x      (mean_lx),
      .mean_y      (mean_ly)
   );

   acpd_lane #(.WINDOW (WINDOW)) u_lane_right (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .idx         (base_idx),
      .measured_x  (req_measured_right_x),
      .measured_y  (req_measured_right_y),
      .requested_x (req_requested_right_x),
      .requested_y (req_requested_right_y),
      .mean_x      (mean_rx),
      .mean_y      (mean_ry)
   );

   acpd_judge u_judge_left (
      .clock       (clock),
      .reset       (reset),
      .load        (s2_move),
      .clear       (s2_clear_ff),
      .mean_x      (mean_lx),
      .mean_y      (mean_ly),
      .threshold_x (thr_x_ff),
      .threshold_y (thr_y_ff),
      .contact     (rsp_left_contact),
      .direction   (rsp_direction_left),
      .duration    (rsp_left_duration)
   );

   acpd_judge u_judge_right (
      .clock       (clock),
      .reset       (reset),
      .load        (s2_move),
      .clear       (s2_clear_ff),
      .mean_x      (mean_rx),
      .mean_y      (mean_ry),
      .threshold_x (thr_x_ff),
      .threshold_y (thr_y_ff),
      .contact     (rsp_right_contact),
      .direction   (rsp_direction_right),
      .duration    (rsp_right_duration)
   );

   assign fill_grow  = accept && !req_clear_history && !full_now;
   assign left_idle  = rsp_left_duration == '0 && rsp_direction_left == DIR_NONE;
   assign right_busy = rsp_right_duration != '0 && rsp_direction_right != DIR_NONE;

   `ASSERT_IMPLY(a_fill_bound, clock, reset, 1'b1, fill_ff <= FILL_W'(WINDOW))
   `ASSERT_NEXT(a_fill_step, clock, reset, fill_grow, fill_ff == FILL_W'($past(fill_ff) + 1'b1))
   `ASSERT_IMPLY(a_no_contact, clock, reset, rsp_valid_ff && !rsp_left_contact, left_idle)
   `ASSERT_IMPLY(a_contact, clock, reset, rsp_valid_ff && rsp_right_contact, right_busy)

endmodule

>>> test/arm_contact_push_detector_tb.sv
module arm_contact_push_detector_tb;
   import acpd_pkg::*;

   localparam int HIST_DEPTH   = 16;
   localparam int WIN_SHIFT    = $clog2(HIST_DEPTH);
   localparam int SUM_W        = 22;
   localparam int POS_MAX      = 32767;
   localparam int POS_MIN      = -32768;
   localparam int ERR_MAX      = POS_MAX - POS_MIN;
   localparam int THR_MAX      = (1 << THR_W) - 1;
   localparam int GAP_PCT      = 11;
   localparam int PHASE_TICKS  = 115;
   localparam int RUN_TICKS    = 100;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   typedef struct packed {
      logic                     clear;
      logic signed [POS_W-1:0]  meas_lx;
      logic signed [POS_W-1:0]  meas_ly;
      logic signed [POS_W-1:0]  req_lx;
      logic signed [POS_W-1:0]  req_ly;
      logic signed [POS_W-1:0]  meas_rx;
      logic signed [POS_W-1:0]  meas_ry;
      logic signed [POS_W-1:0]  req_rx;
      logic signed [POS_W-1:0]  req_ry;
   } tick_type;

   localparam int TICK_W = $bits(tick_type);

   typedef struct packed {
      logic               contact;
      dir_type            dir;
      logic [DUR_W-1:0]   dur;
   } arm_report_type;

   typedef struct packed {
      arm_report_type left;
      arm_report_type right;
   } push_report_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   tick_type               req_tick = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_left_contact;
   logic                   rsp_right_contact;
   logic [DIR_W-1:0]       rsp_direction_left;
   logic [DIR_W-1:0]       rsp_direction_right;
   logic [DUR_W-1:0]       rsp_left_duration;
   logic [DUR_W-1:0]       rsp_right_duration;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = CSR_THRESHOLD_X;
   logic [THR_W-1:0]       csr_wdata = '0;

   tick_type         pending_ticks[$];
   push_report_type  predicted_reports[$];
   push_report_type  want;
   bit               no_gaps = 1'b0;
   int               mismatches = 0;
   int               stall_cycles = 0;

   // predictor state
   logic [THR_W-1:0]                  limit_x;
   logic [THR_W-1:0]                  limit_y;
   logic signed [ERR_W-1:0]           err_hist [2][2][HIST_DEPTH];
   logic [WIN_SHIFT-1:0]              hist_wr;
   logic [WIN_SHIFT:0]                hist_fill;
   logic signed [SUM_W-1:0]           err_sum [2][2];
   logic signed [MEAN_W-1:0]          err_mean [2][2];
   logic [DUR_W-1:0]                  contact_ticks [2];

   arm_contact_push_detector #(.WINDOW(HIST_DEPTH)) DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_clear_history     (req_tick.clear),
      .req_measured_left_x   (req_tick.meas_lx),
      .req_measured_left_y   (req_tick.meas_ly),
      .req_requested_left_x  (req_tick.req_lx),
      .req_requested_left_y  (req_tick.req_ly),
      .req_measured_right_x  (req_tick.meas_rx),
      .req_measured_right_y  (req_tick.meas_ry),
      .req_requested_right_x (req_tick.req_rx),
      .req_requested_right_y (req_tick.req_ry),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_left_contact      (rsp_left_contact),
      .rsp_right_contact     (rsp_right_contact),
      .rsp_direction_left    (rsp_direction_left),
      .rsp_direction_right   (rsp_direction_right),
      .rsp_left_duration     (rsp_left_duration),
      .rsp_right_duration    (rsp_right_duration),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic void forget_history();
      int a;
      int x;
      hist_wr   = '0;
      hist_fill = '0;
      for (a = 0; a < 2; a++) begin
         contact_ticks[a] = '0;
         for (x = 0; x < 2; x++) begin
            err_sum[a][x]  = '0;
            err_mean[a][x] = '0;
         end
      end
   endfunction

   function automatic logic signed [ERR_W-1:0] pos_err(logic signed [POS_W-1:0] meas,
                                                       logic signed [POS_W-1:0] target);
      return {meas[POS_W-1], meas} - {target[POS_W-1], target};
   endfunction

   function automatic arm_report_type judge_arm(int arm);
      logic [MEAN_W-1:0] mag_x;
      logic [MEAN_W-1:0] mag_y;
      logic              over_x;
      logic              over_y;
      arm_report_type    r;
      mag_x  = (err_mean[arm][0] < 0) ? -err_mean[arm][0] : err_mean[arm][0];
      mag_y  = (err_mean[arm][1] < 0) ? -err_mean[arm][1] : err_mean[arm][1];
      over_x = mag_x > MEAN_W'(limit_x);
      over_y = mag_y > MEAN_W'(limit_y);
      r.contact = over_x | over_y;
      if (over_x) begin
         r.dir = (err_mean[arm][0] < 0) ? DIR_BACKWARD : DIR_FORWARD;
      end else if (over_y) begin
         r.dir = (err_mean[arm][1] < 0) ? DIR_RIGHT : DIR_LEFT;
      end else begin
         r.dir = DIR_NONE;
      end
      if (!r.contact) begin
         contact_ticks[arm] = '0;
      end else if (contact_ticks[arm] != '1) begin
         contact_ticks[arm] = contact_ticks[arm] + 1'b1;
      end
      r.dur = contact_ticks[arm];
      return r;
   endfunction

   function automatic push_report_type predict_push(tick_type t);
      logic signed [ERR_W-1:0] e [2][2];
      logic                    was_full;
      int                      a;
      int                      x;
      push_report_type         r;
      if (t.clear) begin
         forget_history();
      end
      e[0][0]  = pos_err(t.meas_lx, t.req_lx);
      e[0][1]  = pos_err(t.meas_ly, t.req_ly);
      e[1][0]  = pos_err(t.meas_rx, t.req_rx);
      e[1][1]  = pos_err(t.meas_ry, t.req_ry);
      was_full = hist_fill == HIST_DEPTH;
      for (a = 0; a < 2; a++) begin
         for (x = 0; x < 2; x++) begin
            if (was_full) begin
               err_sum[a][x] = err_sum[a][x] - err_hist[a][x][hist_wr];
            end
            err_sum[a][x] = err_sum[a][x] + e[a][x];
            err_hist[a][x][hist_wr] = e[a][x];
         end
      end
      hist_wr = hist_wr + 1'b1;
      if (!was_full) begin
         hist_fill = hist_fill + 1'b1;
      end
      if (hist_fill == HIST_DEPTH) begin
         for (a = 0; a < 2; a++) begin
            for (x = 0; x < 2; x++) begin
               err_mean[a][x] = MEAN_W'(err_sum[a][x] >>> WIN_SHIFT);
            end
         end
      end
      r.left  = judge_arm(0);
      r.right = judge_arm(1);
      return r;
   endfunction

   // picks a random position pair whose difference is the given error
   function automatic void split_err(input int e, output logic signed [POS_W-1:0] meas,
                                     output logic signed [POS_W-1:0] target);
      int lo;
      int hi;
      int rv;
      if (e > ERR_MAX) e = ERR_MAX;
      if (e < -ERR_MAX) e = -ERR_MAX;
      lo     = (e < 0) ? POS_MIN - e : POS_MIN;
      hi     = (e < 0) ? POS_MAX : POS_MAX - e;
      rv     = lo + int'($urandom_range(hi - lo));
      target = POS_W'(rv);
      meas   = POS_W'(rv + e);
   endfunction

   function automatic tick_type make_tick(logic clr, int elx, int ely, int erx, int ery);
      tick_type t;
      t.clear = clr;
      split_err(elx, t.meas_lx, t.req_lx);
      split_err(ely, t.meas_ly, t.req_ly);
      split_err(erx, t.meas_rx, t.req_rx);
      split_err(ery, t.meas_ry, t.req_ry);
      return t;
   endfunction

   function automatic int noisy(int center, int amp);
      return center + int'($urandom_range(2 * amp)) - amp;
   endfunction

   function automatic int pick_bias(int thr);
      int b;
      case ($urandom_range(3))
         0: b = thr + int'($urandom_range(6)) - 3;
         1: b = int'($urandom_range(2 * ERR_MAX)) - ERR_MAX;
         2: b = 0;
         default: b = int'($urandom_range(400));
      endcase
      return $urandom_range(1) ? b : -b;
   endfunction

   // segments of steady error with noise, a few raw requests and clears mixed in
   task automatic queue_random_ticks(input int count);
      int       remaining;
      int       seg;
      int       amp;
      int       i;
      int       k;
      int       bias [4];
      tick_type t;
      remaining = count;
      while (remaining > 0) begin
         seg = $urandom_range(8, 60);
         amp = 1 << $urandom_range(11);
         for (k = 0; k < 4; k++) begin
            bias[k] = pick_bias((k % 2 == 0) ? int'(limit_x) : int'(limit_y));
         end
         for (i = 0; i < seg && remaining > 0; i++) begin
            if ($urandom_range(99) < 10) begin
               t = TICK_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
               t.clear = $urandom_range(99) < 2;
            end else begin
               t = make_tick($urandom_range(99) < 2, noisy(bias[0], amp), noisy(bias[1], amp),
                             noisy(bias[2], amp), noisy(bias[3], amp));
            end
            pending_ticks.push_back(t);
            remaining--;
         end
      end
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [THR_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_THRESHOLD_X) begin
         limit_x = data;
      end else if (idx == CSR_THRESHOLD_Y) begin
         limit_y = data;
      end
      @(negedge clock);
   endtask

   task automatic wait_drain();
      do @(negedge clock);
      while (pending_ticks.size() != 0 || predicted_reports.size() != 0 || req_valid);
   endtask

   task automatic check_field(input string what, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (act_val !== exp_val) begin
         mismatches++;
         $display("%0t %s: expected %0d, got %0d", $time, what, exp_val, act_val);
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_reports.push_back(predict_push(req_tick));
         end
         if (!req_valid || req_ready) begin
            if (pending_ticks.size() != 0 && (no_gaps || $urandom_range(99) >= GAP_PCT)) begin
               req_tick  <= pending_ticks.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      rsp_ready <= !reset && (no_gaps || $urandom_range(99) >= GAP_PCT);
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_reports.size() == 0) begin
            mismatches++;
            $display("%0t response with no request pending", $time);
         end else begin
            want = predicted_reports.pop_front();
            check_field("left_contact", want.left.contact, rsp_left_contact);
            check_field("right_contact", want.right.contact, rsp_right_contact);
            check_field("direction_left", want.left.dir, rsp_direction_left);
            check_field("direction_right", want.right.dir, rsp_direction_right);
            check_field("left_duration", want.left.dur, rsp_left_duration);
            check_field("right_duration", want.right.dur, rsp_right_duration);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("arm_contact_push_detector_tb: done, errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int i;
      int p;
      logic [THR_W-1:0] tx;
      logic [THR_W-1:0] ty;
      forget_history();
      limit_x = THRESHOLD_RESET;
      limit_y = THRESHOLD_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset thresholds: floor rounding of negative sums, threshold boundary
      for (i = 0; i < 20; i++) begin
         pending_ticks.push_back(make_tick(i == 0,
            (i == 0) ? ERR_MAX : (i == 1) ? -ERR_MAX : (i == 2) ? -3281 : 0,
            205, (i == 2) ? 220 : 205, (i == 3) ? 3296 : 0));
      end
      pending_ticks.push_back(make_tick(1'b1, 0, 0, 0, 0));
      pending_ticks.push_back(make_tick(1'b0, ERR_MAX, -ERR_MAX, -ERR_MAX, ERR_MAX));
      wait_drain();

      queue_random_ticks(PHASE_TICKS);
      wait_drain();

      // long contact run without gaps, durations count up on both arms
      csr_write(CSR_THRESHOLD_X, '0);
      csr_write(CSR_THRESHOLD_Y, THR_W'(THR_MAX));
      no_gaps = 1'b1;
      pending_ticks.push_back(make_tick(1'b1, 1, 0, -ERR_MAX, 0));
      for (i = 0; i < RUN_TICKS; i++) begin
         pending_ticks.push_back(make_tick(1'b0, 1, noisy(0, POS_MAX), -ERR_MAX,
                                           noisy(0, POS_MAX)));
      end
      wait_drain();
      no_gaps = 1'b0;

      for (p = 0; p < 4; p++) begin
         case (p)
            0: begin
               tx = THR_W'(THR_MAX);
               ty = '0;
            end
            1: begin
               tx = THR_W'($urandom);
               ty = THR_W'($urandom);
            end
            2: begin
               tx = THR_W'($urandom_range(300));
               ty = THR_W'($urandom_range(300));
            end
            default: begin
               tx = '0;
               ty = '0;
            end
         endcase
         csr_write(CSR_THRESHOLD_X, tx);
         csr_write((p % 2 == 0) ? CSR_SPARE_LO : CSR_SPARE_HI, THR_W'($urandom));
         csr_write(CSR_THRESHOLD_Y, ty);
         queue_random_ticks(PHASE_TICKS);
         wait_drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("arm_contact_push_detector_tb: done, clean");
      end else begin
         $display("arm_contact_push_detector_tb: done, errors");
      end
      $finish;
   end
endmodule

>>> arm_contact_push_detector.f
+incdir+sv
sv/acpd_pkg.sv
sv/acpd_ram.sv
sv/acpd_lane.sv
sv/acpd_judge.sv
sv/arm_contact_push_detector.sv
test/arm_contact_push_detector_tb.sv
